FILE: rtl/core/sfdx_pkg.sv
`timescale 1ns / 1ps

package sfdx_pkg;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_MAX_LENGTH    = 2'd2
    } cfg_index_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FRAMING  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [7:0]  HEADER_FIRST_RESET  = 8'h55;
    localparam logic [7:0]  HEADER_SECOND_RESET = 8'h33;
    localparam logic [15:0] MAX_LENGTH_RESET    = 16'd1024;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [15:0] max_length;
    } sfdx_cfg_t;

    typedef struct packed {
        logic        fire;
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [1:0]  status;
        logic [15:0] packet_length;
    } sfdx_result_t;

endpackage

FILE: rtl/core/sfdx_cfg.sv
`timescale 1ns / 1ps

module sfdx_cfg
    import sfdx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output sfdx_cfg_t   cfg
);

    sfdx_cfg_t cfg_reg;
    sfdx_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_HEADER_FIRST:  cfg_next.header_first  = wr_data[7:0];
                CFG_HEADER_SECOND: cfg_next.header_second = wr_data[7:0];
                CFG_MAX_LENGTH:    cfg_next.max_length    = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RESET;
            cfg_reg.header_second <= HEADER_SECOND_RESET;
            cfg_reg.max_length    <= MAX_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/sfdx_core.sv
`timescale 1ns / 1ps

module sfdx_core
    import sfdx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   rx_byte,
    input  sfdx_cfg_t    cfg,
    output sfdx_result_t result
);

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [15:0] decl_reg, decl_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  chk_reg, chk_next;

    logic [15:0] full_len;
    logic [15:0] rem_dec;
    logic        is_first;

    assign full_len = {decl_reg[15:8], rx_byte};
    assign rem_dec  = rem_reg - 16'd1;
    assign is_first = (rx_byte == cfg.header_first);

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        decl_next  = decl_reg;
        rem_next   = rem_reg;
        chk_next   = chk_reg;
        result     = '0;

        unique case (phase_reg)
            PH_HDR2:
            begin
                if (rx_byte == cfg.header_second)
                begin
                    phase_next = PH_LENHI;
                    esc_next   = 1'b0;
                    decl_next  = '0;
                    chk_next   = '0;
                end
                else
                begin
                    result.fire        = 1'b1;
                    result.result_kind = KIND_STATUS;
                    result.status      = ST_FRAMING;
                end
            end
            PH_LENHI, PH_LENLO, PH_DATA, PH_CHECK:
            begin
                if (esc_reg && !is_first)
                begin
                    result.fire        = 1'b1;
                    result.result_kind = KIND_STATUS;
                    result.status      = ST_FRAMING;
                    if (phase_reg == PH_DATA || phase_reg == PH_CHECK)
                    begin
                        result.packet_length = decl_reg;
                    end
                end
                else if (!esc_reg && is_first)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    case (phase_reg)
                        PH_LENHI:
                        begin
                            decl_next  = {rx_byte, 8'h00};
                            chk_next   = rx_byte;
                            phase_next = PH_LENLO;
                        end
                        PH_LENLO:
                        begin
                            decl_next = full_len;
                            chk_next  = chk_reg ^ rx_byte;
                            if (full_len > cfg.max_length)
                            begin
                                result.fire          = 1'b1;
                                result.result_kind   = KIND_STATUS;
                                result.status        = ST_TOO_LONG;
                                result.packet_length = full_len;
                            end
                            else
                            begin
                                rem_next   = full_len;
                                phase_next = (full_len == 16'd0) ? PH_CHECK : PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            chk_next = chk_reg ^ rx_byte;
                            rem_next = rem_dec;
                            if (rem_dec == 16'd0)
                            begin
                                phase_next = PH_CHECK;
                            end
                            result.fire          = 1'b1;
                            result.result_kind   = KIND_PAYLOAD;
                            result.payload_byte  = rx_byte;
                            result.byte_index    = decl_reg - rem_reg;
                            result.packet_length = decl_reg;
                        end
                        default:
                        begin
                            result.fire          = 1'b1;
                            result.result_kind   = KIND_STATUS;
                            result.status        = (rx_byte == chk_reg) ? ST_OK : ST_MISMATCH;
                            result.packet_length = decl_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = is_first ? PH_HDR2 : PH_HUNT;
                esc_next   = 1'b0;
                decl_next  = '0;
                rem_next   = '0;
                chk_next   = '0;
            end
        endcase

        if (result.fire && result.result_kind == KIND_STATUS)
        begin
            phase_next = PH_HUNT;
            esc_next   = 1'b0;
            decl_next  = '0;
            rem_next   = '0;
            chk_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            decl_reg  <= '0;
            rem_reg   <= '0;
            chk_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            decl_reg  <= decl_next;
            rem_reg   <= rem_next;
            chk_reg   <= chk_next;
        end
    end

    // An escape can only be outstanding inside the stuffed part of a packet.
    a_esc_in_stuffed: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg == PH_LENHI || phase_reg == PH_LENLO ||
                     phase_reg == PH_DATA || phase_reg == PH_CHECK))
        else $error("escape pending outside the stuffed phases");

    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rem_reg != 16'd0 && rem_reg <= decl_reg))
        else $error("payload count out of range");

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (decl_reg == 16'd0 && rem_reg == 16'd0 &&
                                    chk_reg == 8'd0))
        else $error("packet state not cleared while hunting");

    a_status_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.fire && result.result_kind == KIND_STATUS)
            |=> (phase_reg == PH_HUNT && !esc_reg))
        else $error("no return to hunting after a status result");

endmodule

FILE: rtl/core/sfdx_out.sv
`timescale 1ns / 1ps

module sfdx_out
    import sfdx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  sfdx_result_t result,
    input  logic         take,
    output logic         full,
    output logic         result_kind,
    output logic [7:0]   payload_byte,
    output logic [15:0]  byte_index,
    output logic [1:0]   status,
    output logic [15:0]  packet_length
);

    logic         valid_reg, valid_next;
    sfdx_result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = result.fire;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.fire)
        begin
            data_reg <= result;
        end
    end

    assign full          = valid_reg;
    assign result_kind   = data_reg.result_kind;
    assign payload_byte  = data_reg.payload_byte;
    assign byte_index    = data_reg.byte_index;
    assign status        = data_reg.status;
    assign packet_length = data_reg.packet_length;

endmodule

FILE: rtl/core/stuffed_frame_deframer_xor_check_unit.sv
`timescale 1ns / 1ps

// Channel      Handshake             Payload
// rx           rx_valid / rx_ready   rx_byte
// result       res_valid / res_ready result_kind, payload_byte, byte_index, status,
//                                    packet_length
// cfg          cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each line byte is handled in the cycle it is accepted, and its result is registered.
// A new byte can be accepted every cycle; input stalls only while a result waits.
// rx_ready is high when the result register is empty or being emptied this cycle.
// cfg_ready is always high. Reset restores the register defaults and resumes hunting.

module stuffed_frame_deframer_xor_check_unit
    import sfdx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_index,
    output logic [1:0]  status,
    output logic [15:0] packet_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sfdx_cfg_t    cfg;
    sfdx_result_t result;
    logic         accept;
    logic         full;

    assign cfg_ready = 1'b1;
    assign rx_ready  = !full || res_ready;
    assign accept    = rx_valid && rx_ready;
    assign res_valid = full;

    sfdx_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sfdx_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .result  (result)
    );

    sfdx_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .result        (result),
        .take          (res_ready),
        .full          (full),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .status        (status),
        .packet_length (packet_length)
    );

endmodule

FILE: tb/sv/sfdx_deframe_scoreboard_pkg.sv
`timescale 1ns / 1ps

package sfdx_deframe_scoreboard_pkg;

    import sfdx_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [1:0]  stat;
        logic [15:0] plen;
    } deframed_t;

    class deframe_scoreboard;

        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
        logic [15:0] max_len;

        phase_t      phase;
        bit          esc_pending;
        logic [15:0] decl_len;
        logic [15:0] remaining;
        logic [7:0]  xor_sum;

        deframed_t   pending[$];
        int          mismatches;
        int          bytes_noted;
        int          payloads_seen;
        int          cfg_writes;
        int          status_seen[4];

        function new();
            hdr_first  = HEADER_FIRST_RESET;
            hdr_second = HEADER_SECOND_RESET;
            max_len    = MAX_LENGTH_RESET;
            resync();
        endfunction

        function void resync();
            phase       = PH_HUNT;
            esc_pending = 1'b0;
            decl_len    = 16'h0000;
            remaining   = 16'h0000;
            xor_sum     = 8'h00;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] value);
            cfg_writes++;
            case (idx)
                CFG_HEADER_FIRST:  hdr_first  = value[7:0];
                CFG_HEADER_SECOND: hdr_second = value[7:0];
                CFG_MAX_LENGTH:    max_len    = value;
                default: ;
            endcase
        endfunction

        function void end_packet(logic [1:0] st, logic [15:0] plen);
            deframed_t r;
            r.kind  = KIND_STATUS;
            r.data  = 8'h00;
            r.index = 16'h0000;
            r.stat  = st;
            r.plen  = plen;
            pending.push_back(r);
            resync();
        endfunction

        // Works out what one accepted line byte must produce.
        function void note_byte(logic [7:0] b);
            deframed_t r;
            bytes_noted++;
            if (phase == PH_HDR2)
            begin
                if (b == hdr_second)
                begin
                    phase       = PH_LENHI;
                    esc_pending = 1'b0;
                    decl_len    = 16'h0000;
                    xor_sum     = 8'h00;
                end
                else
                begin
                    end_packet(ST_FRAMING, 16'h0000);
                end
                return;
            end
            if (phase < PH_LENHI || phase > PH_CHECK)
            begin
                resync();
                if (b == hdr_first)
                begin
                    phase = PH_HDR2;
                end
                return;
            end
            if (esc_pending)
            begin
                if (b != hdr_first)
                begin
                    end_packet(ST_FRAMING, (phase >= PH_DATA) ? decl_len : 16'h0000);
                    return;
                end
                esc_pending = 1'b0;
            end
            else if (b == hdr_first)
            begin
                esc_pending = 1'b1;
                return;
            end
            case (phase)
                PH_LENHI:
                begin
                    decl_len = {b, 8'h00};
                    xor_sum  = b;
                    phase    = PH_LENLO;
                end
                PH_LENLO:
                begin
                    decl_len = {decl_len[15:8], b};
                    xor_sum  = xor_sum ^ b;
                    if (decl_len > max_len)
                    begin
                        end_packet(ST_TOO_LONG, decl_len);
                    end
                    else
                    begin
                        remaining = decl_len;
                        if (decl_len == 16'h0000)
                        begin
                            phase = PH_CHECK;
                        end
                        else
                        begin
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    r.kind    = KIND_PAYLOAD;
                    r.data    = b;
                    r.index   = decl_len - remaining;
                    r.stat    = ST_OK;
                    r.plen    = decl_len;
                    pending.push_back(r);
                    xor_sum   = xor_sum ^ b;
                    remaining = remaining - 16'd1;
                    if (remaining == 16'h0000)
                    begin
                        phase = PH_CHECK;
                    end
                end
                default:
                begin
                    end_packet((b == xor_sum) ? ST_OK : ST_MISMATCH, decl_len);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
            begin
                $display("MISMATCH: %s", msg);
            end
            mismatches++;
        endtask

        task check_result(logic kind, logic [7:0] data, logic [15:0] index,
                          logic [1:0] stat, logic [15:0] plen);
            deframed_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind=%0d data=%02h index=%0d status=%0d length=%0d",
                                          kind, data, index, stat, plen));
                return;
            end
            want = pending.pop_front();
            if (want.kind == KIND_STATUS)
            begin
                status_seen[want.stat]++;
            end
            else
            begin
                payloads_seen++;
            end
            if (kind !== want.kind)
            begin
                report_mismatch($sformatf("result_kind %0d, wanted %0d", kind, want.kind));
            end
            if (data !== want.data)
            begin
                report_mismatch($sformatf("payload_byte %02h, wanted %02h", data, want.data));
            end
            if (index !== want.index)
            begin
                report_mismatch($sformatf("byte_index %0d, wanted %0d", index, want.index));
            end
            if (stat !== want.stat)
            begin
                report_mismatch($sformatf("status %0d, wanted %0d", stat, want.stat));
            end
            if (plen !== want.plen)
            begin
                report_mismatch($sformatf("packet_length %0d, wanted %0d", plen, want.plen));
            end
        endtask

    endclass

endpackage

FILE: tb/sv/stuffed_frame_deframer_xor_check_unit_test.sv
`timescale 1ns / 1ps

module stuffed_frame_deframer_xor_check_unit_test
    import sfdx_pkg::*, sfdx_deframe_scoreboard_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic [15:0] packet_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'h0000;

    deframe_scoreboard sb;

    bit rx_took;
    bit cfg_took;
    bit src_idling;
    bit sink_idling;
    int hold_request;
    int hold_left;
    int gap_left;
    int cycles;

    logic [7:0] opening[$] = '{
        8'h00,
        HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'h00, 8'h00, 8'h00,
        HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'h00, 8'h01,
        HEADER_FIRST_RESET, HEADER_FIRST_RESET, 8'h00,
        HEADER_FIRST_RESET, HEADER_FIRST_RESET,
        HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'h00, HEADER_FIRST_RESET, 8'h07,
        HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'h04, 8'h01
    };

    stuffed_frame_deframer_xor_check_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .status        (status),
        .packet_length (packet_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("stuffed_frame_deframer_xor_check_unit_test: FAIL");
            $finish;
        end
    end

    // A result accepted at an edge always belongs to a byte taken at an earlier edge,
    // so it is checked before the byte of the same edge is noted.
    always @(posedge clk)
    begin
        rx_took  = rst_n && rx_valid && rx_ready;
        cfg_took = rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                sb.check_result(result_kind, payload_byte, byte_index, status, packet_length);
            end
            if (rx_valid && rx_ready)
            begin
                sb.note_byte(rx_byte);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.write_register(cfg_index, cfg_data);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            res_ready <= 1'b0;
        end
        else if (sink_idling && $urandom_range(0, 4) == 0)
        begin
            gap_left = $urandom_range(0, 5);
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    task offer_line_byte(logic [7:0] b);
        if (src_idling && $urandom_range(0, 4) == 0)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(negedge clk); while (!rx_took);
    endtask

    task program_register(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_took);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task drain_and_settle();
        rx_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic void push_stuffed(ref logic [7:0] raw[$], input logic [7:0] b,
                                         input logic [7:0] hf);
        raw.push_back(b);
        if (b == hf)
        begin
            raw.push_back(b);
        end
    endfunction

    // Builds one line-level transaction sequence: mostly well-formed packets with
    // random content, the rest corrupted in one of several ways or plain noise.
    task automatic send_random_frame();
        logic [7:0]  hf;
        logic [7:0]  hs;
        logic [7:0]  chk;
        logic [7:0]  pb;
        logic [15:0] len;
        logic [7:0]  raw[$];
        logic [7:0]  body[$];
        int          kind;
        int          cut;
        hf   = sb.hdr_first;
        hs   = sb.hdr_second;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 4))
            begin
                raw.push_back(($urandom_range(0, 3) == 0) ? hf : 8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            raw.push_back(hf);
            if (kind < 12)
            begin
                raw.push_back(hs ^ 8'($urandom_range(1, 255)));
            end
            else
            begin
                raw.push_back(hs);
                if ($urandom_range(0, 15) == 0)
                begin
                    len = 16'($urandom_range(9, 64));
                end
                else
                begin
                    len = 16'($urandom_range(0, 8));
                end
                if (len > sb.max_len)
                begin
                    len = sb.max_len;
                end
                if (kind >= 22 && kind < 30 && sb.max_len != 16'hFFFF)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        len = sb.max_len + 16'd1;
                    end
                    else
                    begin
                        len = 16'($urandom_range(int'(sb.max_len) + 1, 65535));
                    end
                    push_stuffed(raw, len[15:8], hf);
                    push_stuffed(raw, len[7:0], hf);
                end
                else
                begin
                    chk = len[15:8] ^ len[7:0];
                    push_stuffed(body, len[15:8], hf);
                    push_stuffed(body, len[7:0], hf);
                    for (int i = 0; i < int'(len); i++)
                    begin
                        pb  = ($urandom_range(0, 5) == 0) ? hf : 8'($urandom_range(0, 255));
                        chk = chk ^ pb;
                        push_stuffed(body, pb, hf);
                    end
                    if (kind >= 30 && kind < 38)
                    begin
                        chk = chk ^ 8'($urandom_range(1, 255));
                    end
                    push_stuffed(body, chk, hf);
                    if (kind >= 12 && kind < 22)
                    begin
                        cut = $urandom_range(0, body.size() - 1);
                        body = body[0:cut];
                        body[cut] = hf;
                        body.push_back(hf ^ 8'($urandom_range(1, 255)));
                    end
                    else if (kind >= 38 && kind < 42)
                    begin
                        cut = $urandom_range(0, body.size() - 1);
                        body = body[0:cut];
                    end
                    foreach (body[i])
                    begin
                        raw.push_back(body[i]);
                    end
                end
            end
        end
        foreach (raw[i])
        begin
            offer_line_byte(raw[i]);
        end
    endtask

    initial
    begin
        int target;
        bit paused;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        foreach (opening[i])
        begin
            offer_line_byte(opening[i]);
        end
        for (int p = 0; p < 6; p++)
        begin
            drain_and_settle();
            case (p)
                0:
                begin
                    program_register(CFG_HEADER_FIRST, 16'h0000);
                    program_register(CFG_HEADER_SECOND, 16'h00FF);
                    program_register(CFG_MAX_LENGTH, 16'h0000);
                end
                1:
                begin
                    program_register(CFG_HEADER_FIRST, 16'h00FF);
                    program_register(CFG_HEADER_SECOND, 16'h0000);
                    program_register(CFG_MAX_LENGTH, 16'hFFFF);
                    src_idling   = 1'b0;
                    hold_request = 300;
                end
                2:
                begin
                    program_register(CFG_HEADER_FIRST, 16'h00A5);
                    program_register(CFG_HEADER_SECOND, 16'h00A5);
                    program_register(CFG_MAX_LENGTH, 16'd16);
                    src_idling  = 1'b1;
                    sink_idling = 1'b0;
                end
                3:
                begin
                    program_register(CFG_HEADER_FIRST, 16'($urandom_range(0, 65535)));
                    program_register(CFG_HEADER_SECOND, 16'($urandom_range(0, 65535)));
                    program_register(CFG_MAX_LENGTH, 16'($urandom_range(0, 60)));
                    sink_idling = 1'b1;
                end
                4:
                begin
                    program_register(CFG_SPARE, 16'($urandom_range(0, 65535)));
                    program_register(CFG_HEADER_FIRST, {8'h00, HEADER_FIRST_RESET});
                    program_register(CFG_HEADER_SECOND, {8'h00, HEADER_SECOND_RESET});
                    program_register(CFG_MAX_LENGTH, MAX_LENGTH_RESET);
                end
                default:
                begin
                    program_register(CFG_HEADER_FIRST, 16'($urandom_range(0, 255)));
                    program_register(CFG_HEADER_SECOND, 16'($urandom_range(0, 255)));
                    program_register(CFG_MAX_LENGTH, 16'd40);
                    src_idling  = 1'b0;
                    sink_idling = 1'b0;
                end
            endcase
            target = sb.bytes_noted + 138;
            while (sb.bytes_noted < target)
            begin
                send_random_frame();
                if (p == 3 && !paused && sb.bytes_noted > target - 70)
                begin
                    drain_and_settle();
                    paused = 1'b1;
                end
            end
        end
        drain_and_settle();
        repeat (10) @(negedge clk);
        while (sb.pending.size() != 0)
        begin
            sb.report_mismatch("expected result never arrived");
            void'(sb.pending.pop_front());
        end
        $display("Covered %0d line bytes and %0d register writes; %0d payload bytes recovered.",
                 sb.bytes_noted, sb.cfg_writes, sb.payloads_seen);
        $display("End results: %0d ok, %0d framing, %0d checksum mismatch, %0d too long.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FRAMING],
                 sb.status_seen[ST_MISMATCH], sb.status_seen[ST_TOO_LONG]);
        if (sb.mismatches == 0)
        begin
            $display("stuffed_frame_deframer_xor_check_unit_test: PASS");
        end
        else
        begin
            $display("stuffed_frame_deframer_xor_check_unit_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sfdx_pkg.sv
rtl/core/sfdx_cfg.sv
rtl/core/sfdx_core.sv
rtl/core/sfdx_out.sv
rtl/core/stuffed_frame_deframer_xor_check_unit.sv
tb/sv/sfdx_deframe_scoreboard_pkg.sv
tb/sv/stuffed_frame_deframer_xor_check_unit_test.sv
